// File: sv/utf8_display_width_unit_assert.svh
// Assertion macros shared by the display width unit.
// All checks are sampled on i_clk and are off while i_rst_n is low.
`ifndef UTF8_DISPLAY_WIDTH_UNIT_ASSERT_SVH
`define UTF8_DISPLAY_WIDTH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/utf8dw_pkg.sv
package utf8dw_pkg;

    // Widths of the counters, the code point and the stream fields, and the count of wide ranges.
    localparam int unsigned CntW    = 16;
    localparam int unsigned OutW    = 16;
    localparam int unsigned CpW     = 21;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned NumWide = 48;
    localparam int unsigned MDataW  = 40;

    typedef logic [CpW-1:0]  t_cp;
    typedef logic [CntW-1:0] t_cnt;

    // One decoded byte: what it does to the per-string counters.
    typedef struct packed {
        logic valid_byte; // nonzero byte, counted in the string length
        logic is_end;     // string ends with this transfer
        logic lead;       // a new character starts at this byte
        logic done;       // a character is finished by this transfer
        logic narrow;     // finished character is a one-byte character
        logic trunc;      // finished character was cut off by the end
        t_cp  cp;         // code point of the finished character
    } t_char_evt;

    // Fields of one result.
    typedef struct packed {
        logic            truncated_char;
        logic [OutW-1:0] column_byte_offset;
        logic [OutW-1:0] total_columns;
    } t_result;

    // Inclusive bounds of the double-width code point ranges.
    localparam t_cp WIDE_LO [NumWide] = '{
        21'h01100, 21'h0231A, 21'h02329, 21'h023E9, 21'h023F0, 21'h023F3,
        21'h025FD, 21'h02614, 21'h02648, 21'h0267F, 21'h02693, 21'h026A1,
        21'h026AA, 21'h026BD, 21'h026C4, 21'h026CE, 21'h026D4, 21'h026EA,
        21'h026F2, 21'h026F5, 21'h026FA, 21'h026FD, 21'h02705, 21'h0270A,
        21'h02728, 21'h0274C, 21'h0274E, 21'h02753, 21'h02757, 21'h02795,
        21'h027B0, 21'h027BF, 21'h02B1B, 21'h02B50, 21'h02B55, 21'h02E80,
        21'h03041, 21'h03400, 21'h04E00, 21'h0A000, 21'h0AC00, 21'h0F900,
        21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F1E6, 21'h1F300, 21'h20000
    };

    localparam t_cp WIDE_HI [NumWide] = '{
        21'h0115F, 21'h0231B, 21'h0232A, 21'h023EC, 21'h023F0, 21'h023F3,
        21'h025FE, 21'h02615, 21'h02653, 21'h0267F, 21'h02693, 21'h026A1,
        21'h026AB, 21'h026BE, 21'h026C5, 21'h026CE, 21'h026D4, 21'h026EA,
        21'h026F3, 21'h026F5, 21'h026FA, 21'h026FD, 21'h02705, 21'h0270B,
        21'h02728, 21'h0274C, 21'h0274E, 21'h02755, 21'h02757, 21'h02797,
        21'h027B0, 21'h027BF, 21'h02B1C, 21'h02B50, 21'h02B55, 21'h0303E,
        21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF,
        21'h0FE4F, 21'h0FF60, 21'h0FFE6, 21'h1F1FF, 21'h1FAFF, 21'h3FFFD
    };

endpackage

// File: sv/utf8_display_width_unit.sv
// UTF-8 display width unit.
// The slave stream carries one string byte per transfer: i_s_tdata is the byte
// and i_s_tlast marks the last nonzero byte of a string. A zero byte also ends
// the string and is not counted. Each ended string yields one transfer on the
// master stream with its total display columns, the byte offset of the
// character that covers the target column (or the string length if none does)
// and a flag for a character cut off by the end of the string.
// The target column is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// do so only while the unit is idle, as the unit itself does not enforce it.
// Timing: an accepted byte waits in the input register and is processed from
// there; processing the ending byte loads the result register, which drives
// o_m_tvalid.
// Throughput: one byte per cycle unless a string end stalls; the decode logic,
// the 48 parallel range comparators and saturating counters are combinational.
// While a result waits for i_m_tready, bytes that do not end a string keep
// flowing; a byte that ends a string waits in the input register until the
// output register is free, and o_s_tready drops behind it.
// Reset clears the string state, the valid flags of both registers and the target column.
`include "utf8_display_width_unit_assert.svh"

module utf8_display_width_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Fields, lowest bit up: byte_value[7:0].
    input  logic [utf8dw_pkg::ByteW-1:0]        i_s_tdata,
    input  logic                                i_s_tlast,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // Fields, lowest bit up: total_columns[15:0], column_byte_offset[31:16],
    // truncated_char[32], zero fill[39:33].
    output logic [utf8dw_pkg::MDataW-1:0]       o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_wr_en,
    input  logic [utf8dw_pkg::OutW-1:0]         i_cfg_wr_data
);

    logic                              r_in_valid;
    logic [utf8dw_pkg::ByteW-1:0]      r_in_byte;
    logic                              r_in_last;
    logic                              r_out_valid;
    utf8dw_pkg::t_result               r_out;
    logic [utf8dw_pkg::OutW-1:0]       r_target;

    utf8dw_pkg::t_char_evt             evt;
    utf8dw_pkg::t_result               result;
    logic                              wide;
    logic                              out_free;
    logic                              advance;

    // Handshake: a byte moves on unless it ends a string and the output is full.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!evt.is_end || out_free);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(utf8dw_pkg::MDataW - $bits(utf8dw_pkg::t_result)){1'b0}}, r_out};

    utf8dw_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_evt   (evt)
    );

    utf8dw_wide_lookup u_wide (
        .i_cp   (evt.cp),
        .o_wide (wide)
    );

    utf8dw_count u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_evt    (evt),
        .i_wide   (wide),
        .i_target (r_target),
        .o_result (result)
    );

    // Input register and target column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_target   <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Result register: loads when a string ends, empties on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && evt.is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && evt.is_end) begin
            r_out <= result;
        end
    end

    `UDW_ASSERT_SAME(a_end_waits, r_in_valid && evt.is_end && r_out_valid && !i_m_tready, !o_s_tready && !advance, "string end passed a full output register")
    `UDW_ASSERT_NEXT(a_result_loaded, r_in_valid && evt.is_end && out_free, r_out_valid, "result of an ended string was not loaded")
    `UDW_ASSERT_NEXT(a_result_held, r_out_valid && !i_m_tready, r_out_valid && $stable(r_out), "pending result lost or changed")

endmodule

// File: sv/utf8dw_decode.sv
`include "utf8_display_width_unit_assert.svh"

module utf8dw_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_byte,
    input  logic                      i_last,
    output utf8dw_pkg::t_char_evt     o_evt
);

    logic [1:0]       r_bse;
    utf8dw_pkg::t_cp  r_acc;
    logic [1:0]       n_bse;
    utf8dw_pkg::t_cp  n_acc;
    logic [1:0]       bse_a;
    utf8dw_pkg::t_cp  acc_a;

    // Decode one byte against the pending sequence, then close a cut-off
    // character if the string ends here.
    always_comb begin
        o_evt            = '0;
        o_evt.valid_byte = (i_byte != 8'h00);
        o_evt.is_end     = (i_byte == 8'h00) || i_last;
        bse_a            = r_bse;
        acc_a            = r_acc;
        if (o_evt.valid_byte) begin
            if (r_bse != 2'd0) begin
                acc_a = {r_acc[14:0], i_byte[5:0]};
                bse_a = r_bse - 2'd1;
                if (bse_a == 2'd0) begin
                    o_evt.done = 1'b1;
                    o_evt.cp   = acc_a;
                end
            end else begin
                o_evt.lead = 1'b1;
                if ((i_byte & 8'hE0) == 8'hC0) begin
                    acc_a = {16'd0, i_byte[4:0]};
                    bse_a = 2'd1;
                end else if ((i_byte & 8'hF0) == 8'hE0) begin
                    acc_a = {17'd0, i_byte[3:0]};
                    bse_a = 2'd2;
                end else if ((i_byte & 8'hF8) == 8'hF0) begin
                    acc_a = {18'd0, i_byte[2:0]};
                    bse_a = 2'd3;
                end else begin
                    o_evt.done   = 1'b1;
                    o_evt.narrow = 1'b1;
                end
            end
        end
        // Missing continuation bits of a truncated character read as zero.
        if (o_evt.is_end && (bse_a != 2'd0)) begin
            o_evt.done  = 1'b1;
            o_evt.trunc = 1'b1;
            case (bse_a)
                2'd1:    o_evt.cp = {acc_a[14:0], 6'd0};
                2'd2:    o_evt.cp = {acc_a[8:0], 12'd0};
                2'd3:    o_evt.cp = {acc_a[2:0], 18'd0};
                default: o_evt.cp = acc_a;
            endcase
        end
        n_bse = o_evt.is_end ? 2'd0 : bse_a;
        n_acc = o_evt.is_end ? '0 : acc_a;
    end

    // Sequence state advances once per processed transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bse <= 2'd0;
            r_acc <= '0;
        end else if (i_step) begin
            r_bse <= n_bse;
            r_acc <= n_acc;
        end
    end

    `UDW_ASSERT_NEXT(a_end_clears_seq, i_step && o_evt.is_end, r_bse == 2'd0, "sequence not cleared at end of string")

endmodule

// File: sv/utf8dw_wide_lookup.sv
module utf8dw_wide_lookup (
    input  utf8dw_pkg::t_cp  i_cp,
    output logic             o_wide
);

    logic [utf8dw_pkg::NumWide-1:0] hit;

    // All range comparators work in parallel.
    always_comb begin
        for (int k = 0; k < utf8dw_pkg::NumWide; k++) begin
            hit[k] = (i_cp >= utf8dw_pkg::WIDE_LO[k]) && (i_cp <= utf8dw_pkg::WIDE_HI[k]);
        end
        o_wide = |hit;
    end

endmodule

// File: sv/utf8dw_count.sv
`include "utf8_display_width_unit_assert.svh"

module utf8dw_count (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  utf8dw_pkg::t_char_evt             i_evt,
    input  logic                              i_wide,
    input  logic [utf8dw_pkg::OutW-1:0]       i_target,
    output utf8dw_pkg::t_result               o_result
);

    localparam utf8dw_pkg::t_cnt CntMax = '1;

    utf8dw_pkg::t_cnt      r_col;
    utf8dw_pkg::t_cnt      r_bc;
    utf8dw_pkg::t_cnt      r_cs;
    logic                  r_found;
    utf8dw_pkg::t_cnt      r_off;

    utf8dw_pkg::t_cnt      n_col;
    utf8dw_pkg::t_cnt      n_bc;
    utf8dw_pkg::t_cnt      n_cs;
    logic                  n_found;
    utf8dw_pkg::t_cnt      n_off;

    logic [1:0]                   width;
    logic [utf8dw_pkg::CntW:0]    col_sum;
    logic [utf8dw_pkg::CntW:0]    bc_sum;
    logic                         hit;
    utf8dw_pkg::t_cnt             col_a;
    utf8dw_pkg::t_cnt             bc_a;
    utf8dw_pkg::t_cnt             start;
    logic                         found_a;
    utf8dw_pkg::t_cnt             off_a;

    // Column and byte accounting for one processed transfer.
    always_comb begin
        if (!i_evt.done) begin
            width = 2'd0;
        end else if (i_wide && !i_evt.narrow) begin
            width = 2'd2;
        end else begin
            width = 2'd1;
        end
        col_sum = {1'b0, r_col} + {{(utf8dw_pkg::CntW-1){1'b0}}, width};
        col_a   = col_sum[utf8dw_pkg::CntW] ? CntMax : col_sum[utf8dw_pkg::CntW-1:0];
        bc_sum  = {1'b0, r_bc} + {{utf8dw_pkg::CntW{1'b0}}, i_evt.valid_byte};
        bc_a    = bc_sum[utf8dw_pkg::CntW] ? CntMax : bc_sum[utf8dw_pkg::CntW-1:0];
        start   = i_evt.lead ? r_bc : r_cs;

        // The first character whose right edge passes the target covers it.
        hit     = i_evt.done && !r_found && ({1'b0, i_target} < col_sum);
        found_a = r_found || hit;
        off_a   = hit ? start : r_off;

        o_result.total_columns      = col_a[utf8dw_pkg::OutW-1:0];
        o_result.column_byte_offset = found_a ? off_a[utf8dw_pkg::OutW-1:0]
                                              : bc_a[utf8dw_pkg::OutW-1:0];
        o_result.truncated_char     = i_evt.trunc;

        if (i_evt.is_end) begin
            n_col   = '0;
            n_bc    = '0;
            n_cs    = '0;
            n_found = 1'b0;
            n_off   = '0;
        end else begin
            n_col   = col_a;
            n_bc    = bc_a;
            n_cs    = start;
            n_found = found_a;
            n_off   = off_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_bc    <= '0;
            r_cs    <= '0;
            r_found <= 1'b0;
            r_off   <= '0;
        end else if (i_step) begin
            r_col   <= n_col;
            r_bc    <= n_bc;
            r_cs    <= n_cs;
            r_found <= n_found;
            r_off   <= n_off;
        end
    end

    `UDW_ASSERT_SAME(a_offset_in_string, r_found, r_off <= r_bc, "found offset beyond string length")
    `UDW_ASSERT_NEXT(a_end_clears_counts, i_step && i_evt.is_end, (r_bc == '0) && !r_found, "counters not cleared at end of string")

endmodule
